[rtl/tcls_pkg.sv]
// Shared types and constants for the two-column text line splitter.
// No dependencies; compiled first.
`timescale 1ns / 1ps
`default_nettype none

package tcls_pkg;

  // Default position counter width (the counter itself carries one more bit).
  localparam int OFFSET_BITS_DEFAULT = 24;

  // Fixed field widths of the result and request channels.
  localparam int OUT_OFFSET_BITS = 24;
  localparam int LEN_BITS        = 25;
  localparam int LINE_BITS       = 25;
  localparam int ISSUE_BITS      = 16;
  localparam int CFG_INDEX_BITS  = 2;
  localparam int CFG_DATA_BITS   = 16;

  // Result queue sizing.
  localparam int MAX_RESULTS     = 3;
  localparam int RES_COUNT_BITS  = $clog2(MAX_RESULTS + 1);
  localparam int RESULT_DEPTH    = 4;
  localparam int RES_PTR_BITS    = $clog2(RESULT_DEPTH);

  localparam logic [LINE_BITS-1:0]  LINE_MAX          = '1;
  localparam logic [ISSUE_BITS-1:0] ISSUE_CAP_DEFAULT = 16'd256;

  // Character codes.
  localparam logic [7:0] CH_NUL  = 8'h00;
  localparam logic [7:0] CH_TAB  = 8'h09;
  localparam logic [7:0] CH_LF   = 8'h0A;
  localparam logic [7:0] CH_CR   = 8'h0D;
  localparam logic [7:0] CH_SP   = 8'h20;
  localparam logic [7:0] CH_HASH = 8'h23;

  typedef enum logic [CFG_INDEX_BITS-1:0] {
    CFG_COLUMN_ORDER    = 2'd0,
    CFG_MAX_ISSUE_COUNT = 2'd1
  } cfg_index_t;

  typedef enum logic [1:0] {
    KIND_ENTRY = 2'd0,
    KIND_ISSUE = 2'd1,
    KIND_NUL   = 2'd2,
    KIND_DONE  = 2'd3
  } kind_t;

  typedef struct packed {
    kind_t                      result_kind;
    logic [LINE_BITS-1:0]       line_number;
    logic [OUT_OFFSET_BITS-1:0] key_offset;
    logic [LEN_BITS-1:0]        key_length;
    logic [OUT_OFFSET_BITS-1:0] value_offset;
    logic [LEN_BITS-1:0]        value_length;
    logic                       block_ok;
    logic                       last_result;
  } result_t;

  // Results produced by one byte, in delivery order (slot 0 first).
  typedef struct packed {
    logic [RES_COUNT_BITS-1:0]  count;
    result_t [MAX_RESULTS-1:0]  res;
  } push_t;

  typedef struct packed {
    logic room;   // space for a full set of results from one byte
  } fifo_status_t;

endpackage

`default_nettype wire

[rtl/tcls_text_if.sv]
// Byte request channel of the line splitter.
// Has no dependencies.
`timescale 1ns / 1ps
`default_nettype none

interface tcls_text_if ();
  logic       valid;
  logic       ready;
  logic [7:0] text_byte;
  logic       block_end;

  modport source (output valid, output text_byte, output block_end, input ready);
  modport sink   (input valid, input text_byte, input block_end, output ready);
endinterface

`default_nettype wire

[rtl/tcls_cfg_if.sv]
// Register write channel of the line splitter.
// Depends on tcls_pkg.
`timescale 1ns / 1ps
`default_nettype none

interface tcls_cfg_if import tcls_pkg::*; ();
  logic                      valid;
  logic                      ready;
  logic [CFG_INDEX_BITS-1:0] reg_index;
  logic [CFG_DATA_BITS-1:0]  data;

  modport source (output valid, output reg_index, output data, input ready);
  modport sink   (input valid, input reg_index, input data, output ready);
endinterface

`default_nettype wire

[rtl/tcls_result_if.sv]
// Result channel of the line splitter.
// Depends on tcls_pkg.
`timescale 1ns / 1ps
`default_nettype none

interface tcls_result_if import tcls_pkg::*; ();
  logic                       valid;
  logic                       ready;
  logic [1:0]                 result_kind;
  logic [LINE_BITS-1:0]       line_number;
  logic [OUT_OFFSET_BITS-1:0] key_offset;
  logic [LEN_BITS-1:0]        key_length;
  logic [OUT_OFFSET_BITS-1:0] value_offset;
  logic [LEN_BITS-1:0]        value_length;
  logic                       block_ok;
  logic                       last_result;

  modport source (output valid, output result_kind, output line_number,
                  output key_offset, output key_length, output value_offset,
                  output value_length, output block_ok, output last_result,
                  input ready);
  modport sink   (input valid, input result_kind, input line_number,
                  input key_offset, input key_length, input value_offset,
                  input value_length, input block_ok, input last_result,
                  output ready);
endinterface

`default_nettype wire

[rtl/two_column_text_line_splitter.sv]
// Two-column text line splitter: per-byte scanner plus result queue.
// Depends on tcls_pkg, the three channel interfaces and tcls_result_fifo.
//
// Takes a text block one byte per cycle and reports, for every record, the
// offset and length of its key and value spans. One byte is taken per clock
// whenever the result queue (four deep) has room for three results; every
// byte is handled in the cycle it is accepted and its results go straight
// into the queue, which hands out one result per clock. A normal byte gives
// at most one result, so a stream of bytes runs at one byte per cycle while
// the consumer keeps up. The final byte of a block can give three results
// (pending record, NUL report, block done), which holds the input while they
// drain. Registers may be written at any time the block is idle; the write
// channel is always ready.
`timescale 1ns / 1ps
`default_nettype none

module two_column_text_line_splitter import tcls_pkg::*; #(
  parameter int OFFSET_BITS = OFFSET_BITS_DEFAULT
) (
  input  logic          clk,
  input  logic          rst,
  tcls_text_if.sink     text,
  tcls_cfg_if.sink      cfg,
  tcls_result_if.source result
);

  // Positions saturate at 2^OFFSET_BITS, hence the extra bit.
  localparam int PW = OFFSET_BITS + 1;
  typedef logic [PW-1:0] pos_t;
  localparam pos_t POS_MAX = pos_t'(1) << OFFSET_BITS;

  typedef enum logic [2:0] {
    PH_START,
    PH_COMMENT,
    PH_FIRST,
    PH_GAP1,
    PH_SECOND,
    PH_GAPN
  } phase_t;

  // Configuration registers
  logic                  column_order;
  logic [ISSUE_BITS-1:0] max_issue_count;

  // Scanner state
  phase_t                scan_phase,        scan_phase_next;
  pos_t                  byte_offset,       byte_offset_next;
  logic [LINE_BITS-1:0]  line_count,        line_count_next;
  logic [LINE_BITS-1:0]  record_line,       record_line_next;
  pos_t                  first_token_start, first_token_start_next;
  pos_t                  first_token_end,   first_token_end_next;
  pos_t                  second_part_start, second_part_start_next;
  pos_t                  content_end,       content_end_next;
  pos_t                  prior_token_end,   prior_token_end_next;
  logic [ISSUE_BITS-1:0] issues_sent;
  logic                  nul_seen,          nul_seen_next;
  logic [LINE_BITS-1:0]  nul_line,          nul_line_next;

  logic         text_fire;
  logic         cfg_fire;
  logic         skip_byte;   // trailing NUL on the final byte
  logic         is_blank;
  logic         is_crlf;
  pos_t         pos_succ;
  logic         scan_issue;
  logic         scan_entry;
  logic         end_issue;
  logic         end_entry;
  logic         issue_emit;
  logic         rec_fire;
  logic         nul_fire;
  logic         done_fire;
  result_t      rec_res;
  result_t      nul_res;
  result_t      done_res;
  push_t        push;
  fifo_status_t status;

  function automatic logic [LEN_BITS-1:0] span_len(pos_t s, pos_t e);
    return (e >= s) ? LEN_BITS'(e - s) : '0;
  endfunction

  assign text_fire = text.valid && text.ready;
  assign cfg_fire  = cfg.valid && cfg.ready;
  assign cfg.ready = 1'b1;
  assign text.ready = status.room;

  assign skip_byte = text.block_end && (text.text_byte == CH_NUL);
  assign is_blank  = (text.text_byte == CH_SP) || (text.text_byte == CH_TAB);
  assign is_crlf   = (text.text_byte == CH_CR) || (text.text_byte == CH_LF);
  assign pos_succ  = byte_offset[OFFSET_BITS] ? POS_MAX : byte_offset + pos_t'(1);

  // Byte scan, then end-of-block close of the pending record.
  always_comb begin
    scan_phase_next        = scan_phase;
    byte_offset_next       = byte_offset;
    line_count_next        = line_count;
    record_line_next       = record_line;
    first_token_start_next = first_token_start;
    first_token_end_next   = first_token_end;
    second_part_start_next = second_part_start;
    content_end_next       = content_end;
    prior_token_end_next   = prior_token_end;
    nul_seen_next          = nul_seen;
    nul_line_next          = nul_line;
    scan_issue             = 1'b0;
    scan_entry             = 1'b0;
    end_issue              = 1'b0;
    end_entry              = 1'b0;

    if (text_fire && !skip_byte) begin
      // Inner NUL: only the first one is recorded; splitting treats it as text.
      if (text.text_byte == CH_NUL && !nul_seen) begin
        nul_seen_next = 1'b1;
        nul_line_next = line_count;
      end

      unique case (scan_phase) inside
        PH_START: begin
          if (!is_blank && !is_crlf) begin
            if (text.text_byte == CH_HASH) begin
              scan_phase_next = PH_COMMENT;
            end else begin
              first_token_start_next = byte_offset;
              record_line_next       = line_count;
              scan_phase_next        = PH_FIRST;
            end
          end
        end
        PH_COMMENT: begin
          if (is_crlf) scan_phase_next = PH_START;
        end
        PH_FIRST: begin
          if (is_blank || is_crlf) begin
            first_token_end_next = byte_offset;
            if (is_crlf) begin
              scan_issue      = 1'b1;
              scan_phase_next = PH_START;
            end else begin
              scan_phase_next = PH_GAP1;
            end
          end
        end
        PH_GAP1: begin
          if (is_crlf) begin
            scan_issue      = 1'b1;
            scan_phase_next = PH_START;
          end else if (!is_blank) begin
            second_part_start_next = byte_offset;
            content_end_next       = pos_succ;
            prior_token_end_next   = first_token_end;
            scan_phase_next        = PH_SECOND;
          end
        end
        PH_SECOND, PH_GAPN: begin
          if (is_crlf) begin
            // value-then-key: key ends at the line break
            if (column_order && scan_phase == PH_SECOND) content_end_next = byte_offset;
            scan_entry      = 1'b1;
            scan_phase_next = PH_START;
          end else if (!column_order) begin
            // key-then-value: value end tracks last non-blank byte
            if (!is_blank) content_end_next = pos_succ;
            scan_phase_next = PH_SECOND;
          end else if (scan_phase == PH_SECOND) begin
            if (is_blank) begin
              content_end_next = byte_offset;
              scan_phase_next  = PH_GAPN;
            end
          end else if (!is_blank) begin
            // new token: the previous one becomes part of the value
            prior_token_end_next   = content_end;
            second_part_start_next = byte_offset;
            content_end_next       = pos_succ;
            scan_phase_next        = PH_SECOND;
          end
        end
        default: scan_phase_next = PH_START;
      endcase

      if (text.text_byte == CH_LF && line_count != LINE_MAX) begin
        line_count_next = line_count + LINE_BITS'(1);
      end
      if (!byte_offset[OFFSET_BITS]) byte_offset_next = byte_offset + pos_t'(1);
    end

    if (text_fire && text.block_end) begin
      unique case (scan_phase_next) inside
        PH_FIRST: begin
          first_token_end_next = byte_offset_next;
          end_issue            = 1'b1;
        end
        PH_GAP1: end_issue = 1'b1;
        PH_SECOND: begin
          if (column_order) content_end_next = byte_offset_next;
          end_entry = 1'b1;
        end
        PH_GAPN: end_entry = 1'b1;
        default: ;
      endcase
    end
  end

  // Issue results are capped per block.
  assign issue_emit = (scan_issue || end_issue) && (issues_sent < max_issue_count);
  assign rec_fire   = issue_emit || scan_entry || end_entry;
  assign done_fire  = text_fire && text.block_end;
  assign nul_fire   = done_fire && nul_seen_next;

  always_comb begin
    rec_res             = '0;
    rec_res.line_number = record_line_next;
    if (issue_emit) begin
      rec_res.result_kind = KIND_ISSUE;
    end else if (!column_order) begin
      rec_res.result_kind  = KIND_ENTRY;
      rec_res.key_offset   = OUT_OFFSET_BITS'(first_token_start_next);
      rec_res.key_length   = span_len(first_token_start_next, first_token_end_next);
      rec_res.value_offset = OUT_OFFSET_BITS'(second_part_start_next);
      rec_res.value_length = span_len(second_part_start_next, content_end_next);
    end else begin
      rec_res.result_kind  = KIND_ENTRY;
      rec_res.key_offset   = OUT_OFFSET_BITS'(second_part_start_next);
      rec_res.key_length   = span_len(second_part_start_next, content_end_next);
      rec_res.value_offset = OUT_OFFSET_BITS'(first_token_start_next);
      rec_res.value_length = span_len(first_token_start_next, prior_token_end_next);
    end

    nul_res             = '0;
    nul_res.result_kind = KIND_NUL;
    nul_res.line_number = nul_line_next;

    done_res             = '0;
    done_res.result_kind = KIND_DONE;
    done_res.line_number = line_count_next;
    done_res.block_ok    = !nul_seen_next;
    done_res.last_result = 1'b1;
  end

  // Pack in delivery order: record, NUL report, block done.
  always_comb begin
    push.count  = RES_COUNT_BITS'(rec_fire) + RES_COUNT_BITS'(nul_fire)
                + RES_COUNT_BITS'(done_fire);
    push.res[0] = rec_fire ? rec_res : (nul_fire ? nul_res : done_res);
    push.res[1] = rec_fire ? (nul_fire ? nul_res : done_res) : done_res;
    push.res[2] = done_res;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      column_order    <= 1'b0;
      max_issue_count <= ISSUE_CAP_DEFAULT;
    end else if (cfg_fire) begin
      unique case (cfg.reg_index)
        CFG_COLUMN_ORDER:    column_order    <= cfg.data[0];
        CFG_MAX_ISSUE_COUNT: max_issue_count <= cfg.data;
        default: ;
      endcase
    end
  end

  // The block end returns the scanner to its reset state.
  always_ff @(posedge clk) begin
    if (rst || done_fire) begin
      scan_phase        <= PH_START;
      byte_offset       <= '0;
      line_count        <= LINE_BITS'(1);
      record_line       <= LINE_BITS'(1);
      first_token_start <= '0;
      first_token_end   <= '0;
      second_part_start <= '0;
      content_end       <= '0;
      prior_token_end   <= '0;
      issues_sent       <= '0;
      nul_seen          <= 1'b0;
      nul_line          <= '0;
    end else begin
      scan_phase        <= scan_phase_next;
      byte_offset       <= byte_offset_next;
      line_count        <= line_count_next;
      record_line       <= record_line_next;
      first_token_start <= first_token_start_next;
      first_token_end   <= first_token_end_next;
      second_part_start <= second_part_start_next;
      content_end       <= content_end_next;
      prior_token_end   <= prior_token_end_next;
      nul_seen          <= nul_seen_next;
      nul_line          <= nul_line_next;
      if (issue_emit) issues_sent <= issues_sent + ISSUE_BITS'(1);
    end
  end

  tcls_result_fifo u_result_fifo (
    .clk    (clk),
    .rst    (rst),
    .push   (push),
    .status (status),
    .result (result)
  );

`ifndef SYNTHESIS
  a_push_needs_request: assert property (@(posedge clk) disable iff (rst)
    (push.count != '0) |-> text_fire)
    else $error("results pushed without an accepted request");

  a_block_clears: assert property (@(posedge clk) disable iff (rst)
    done_fire |=> (scan_phase == PH_START) && (byte_offset == '0) && !nul_seen)
    else $error("scanner not cleared after block end");

  a_offset_cap: assert property (@(posedge clk) disable iff (rst)
    byte_offset <= POS_MAX)
    else $error("byte offset beyond saturation");
`endif

endmodule

`default_nettype wire

[rtl/tcls_result_fifo.sv]
// Small result queue: takes up to three results per cycle, hands out one.
// Depends on tcls_pkg and tcls_result_if.
`timescale 1ns / 1ps
`default_nettype none

module tcls_result_fifo import tcls_pkg::*; (
  input  logic            clk,
  input  logic            rst,
  input  push_t           push,
  output fifo_status_t    status,
  tcls_result_if.source   result
);

  localparam int CNT_BITS = RES_PTR_BITS + 1;

  result_t               entries [RESULT_DEPTH];
  logic [RES_PTR_BITS-1:0] wr_ptr;
  logic [RES_PTR_BITS-1:0] rd_ptr;
  logic [CNT_BITS-1:0]     count;
  logic                    pop;
  result_t                 head;

  assign pop  = result.valid && result.ready;
  assign head = entries[rd_ptr];

  always_ff @(posedge clk) begin
    for (int k = 0; k < MAX_RESULTS; k++) begin
      if (RES_COUNT_BITS'(k) < push.count) begin
        entries[wr_ptr + RES_PTR_BITS'(k)] <= push.res[k];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      wr_ptr <= wr_ptr + RES_PTR_BITS'(push.count);
      rd_ptr <= rd_ptr + RES_PTR_BITS'(pop);
      count  <= count + CNT_BITS'(push.count) - CNT_BITS'(pop);
    end
  end

  assign status.room = (count <= CNT_BITS'(RESULT_DEPTH - MAX_RESULTS));

  assign result.valid        = (count != '0);
  assign result.result_kind  = head.result_kind;
  assign result.line_number  = head.line_number;
  assign result.key_offset   = head.key_offset;
  assign result.key_length   = head.key_length;
  assign result.value_offset = head.value_offset;
  assign result.value_length = head.value_length;
  assign result.block_ok     = head.block_ok;
  assign result.last_result  = head.last_result;

`ifndef SYNTHESIS
  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= CNT_BITS'(RESULT_DEPTH))
    else $error("result queue count out of range");

  a_push_with_room: assert property (@(posedge clk) disable iff (rst)
    (push.count != '0) |-> (count <= CNT_BITS'(RESULT_DEPTH - MAX_RESULTS)))
    else $error("results pushed without room");

  a_ptr_track: assert property (@(posedge clk) disable iff (rst)
    RES_PTR_BITS'(wr_ptr - rd_ptr) == count[RES_PTR_BITS-1:0])
    else $error("queue pointers disagree with count");
`endif

endmodule

`default_nettype wire

[test/tcls_span_monitor.sv]
// Span monitor for the two-column text line splitter: watches the three channels,
// predicts every result from the accepted bytes and compares in order.
// Depends on tcls_pkg and the channel interfaces.
`timescale 1ns / 1ps

module tcls_span_monitor import tcls_pkg::*; (
  input  logic   clk,
  input  logic   rst,
  tcls_text_if   text,
  tcls_cfg_if    cfg,
  tcls_result_if result,
  output int     fail_count,
  output int     pending,
  output int     bytes_taken,
  output int     results_checked
);

  localparam logic [24:0] POS_CEIL   = 25'h100_0000;

  typedef enum logic [2:0] {
    SCAN_LINE_START,
    SCAN_COMMENT,
    SCAN_FIRST_TOKEN,
    SCAN_FIRST_GAP,
    SCAN_SECOND_PART,
    SCAN_LATER_GAP
  } scan_state_t;

  // register copies
  logic                  order_vk;
  logic [ISSUE_BITS-1:0] issue_cap;

  // scanner state
  scan_state_t           scan_st;
  logic [24:0]           pos_ctr;
  logic [LINE_BITS-1:0]  line_ctr;
  logic [LINE_BITS-1:0]  rec_line;
  logic [24:0]           tok_start, tok_end, part_start, part_end, prev_end;
  logic [ISSUE_BITS-1:0] issues_out;
  logic                  nul_flag;
  logic [LINE_BITS-1:0]  nul_at_line;

  result_t               span_reports_due[$];

  task automatic clear_scan();
    scan_st     = SCAN_LINE_START;
    pos_ctr     = '0;
    line_ctr    = 25'd1;
    rec_line    = 25'd1;
    tok_start   = '0;
    tok_end     = '0;
    part_start  = '0;
    part_end    = '0;
    prev_end    = '0;
    issues_out  = '0;
    nul_flag    = 1'b0;
    nul_at_line = '0;
  endtask

  function automatic logic [24:0] span(input logic [24:0] from, input logic [24:0] upto);
    return (upto >= from) ? upto - from : 25'd0;
  endfunction

  task automatic post(input kind_t k, input logic [24:0] line,
                      input logic [24:0] ko, input logic [24:0] kl,
                      input logic [24:0] vo, input logic [24:0] vl,
                      input logic ok, input logic fin);
    result_t r;
    r.result_kind  = k;
    r.line_number  = line;
    r.key_offset   = ko[23:0];
    r.key_length   = kl;
    r.value_offset = vo[23:0];
    r.value_length = vl;
    r.block_ok     = ok;
    r.last_result  = fin;
    span_reports_due.push_back(r);
  endtask

  task automatic record_issue();
    if (issues_out < issue_cap) begin
      issues_out++;
      post(KIND_ISSUE, rec_line, '0, '0, '0, '0, 1'b0, 1'b0);
    end
  endtask

  task automatic record_entry();
    if (!order_vk)
      post(KIND_ENTRY, rec_line, tok_start, span(tok_start, tok_end),
           part_start, span(part_start, part_end), 1'b0, 1'b0);
    else
      post(KIND_ENTRY, rec_line, part_start, span(part_start, part_end),
           tok_start, span(tok_start, prev_end), 1'b0, 1'b0);
  endtask

  task automatic advance_scanner(input logic [7:0] b, input logic [24:0] pos);
    logic        blank;
    logic        eol;
    logic [24:0] nxt;
    blank = (b == CH_SP) || (b == CH_TAB);
    eol   = (b == CH_CR) || (b == CH_LF);
    nxt   = (pos < POS_CEIL) ? pos + 25'd1 : POS_CEIL;
    case (scan_st)
      SCAN_LINE_START: begin
        if (!blank && !eol) begin
          if (b == CH_HASH) begin
            scan_st = SCAN_COMMENT;
          end else begin
            tok_start = pos;
            rec_line  = line_ctr;
            scan_st   = SCAN_FIRST_TOKEN;
          end
        end
      end
      SCAN_COMMENT: begin
        if (eol) scan_st = SCAN_LINE_START;
      end
      SCAN_FIRST_TOKEN: begin
        if (blank || eol) begin
          tok_end = pos;
          if (eol) begin
            record_issue();
            scan_st = SCAN_LINE_START;
          end else begin
            scan_st = SCAN_FIRST_GAP;
          end
        end
      end
      SCAN_FIRST_GAP: begin
        if (eol) begin
          record_issue();
          scan_st = SCAN_LINE_START;
        end else if (!blank) begin
          part_start = pos;
          part_end   = nxt;
          prev_end   = tok_end;
          scan_st    = SCAN_SECOND_PART;
        end
      end
      SCAN_SECOND_PART, SCAN_LATER_GAP: begin
        if (eol) begin
          if (order_vk && scan_st == SCAN_SECOND_PART) part_end = pos;
          record_entry();
          scan_st = SCAN_LINE_START;
        end else if (!order_vk) begin
          if (!blank) part_end = nxt;
          scan_st = SCAN_SECOND_PART;
        end else if (scan_st == SCAN_SECOND_PART) begin
          if (blank) begin
            part_end = pos;
            scan_st  = SCAN_LATER_GAP;
          end
        end else if (!blank) begin
          // a new token in value-then-key order: the previous one joins the value
          prev_end   = part_end;
          part_start = pos;
          part_end   = nxt;
          scan_st    = SCAN_SECOND_PART;
        end
      end
      default: scan_st = SCAN_LINE_START;
    endcase
    if (b == CH_LF && line_ctr < LINE_MAX) line_ctr++;
  endtask

  task automatic scan_text_byte(input logic [7:0] b, input logic fin);
    logic [24:0] pos;
    // a NUL on the closing byte is dropped entirely
    if (!(fin && b == CH_NUL)) begin
      pos = pos_ctr;
      if (b == CH_NUL && !nul_flag) begin
        nul_flag    = 1'b1;
        nul_at_line = line_ctr;
      end
      advance_scanner(b, pos);
      if (pos_ctr < POS_CEIL) pos_ctr++;
    end
    if (fin) begin
      case (scan_st)
        SCAN_FIRST_TOKEN: begin
          tok_end = pos_ctr;
          record_issue();
        end
        SCAN_FIRST_GAP: record_issue();
        SCAN_SECOND_PART: begin
          if (order_vk) part_end = pos_ctr;
          record_entry();
        end
        SCAN_LATER_GAP: record_entry();
        default: ;
      endcase
      if (nul_flag) post(KIND_NUL, nul_at_line, '0, '0, '0, '0, 1'b0, 1'b0);
      post(KIND_DONE, line_ctr, '0, '0, '0, '0, !nul_flag, 1'b1);
      clear_scan();
    end
  endtask

  task automatic report_mismatch(input string msg);
    fail_count++;
    $display("ERROR %0t: %s", $realtime, msg);
  endtask

  task automatic check_field(input string name, input logic [24:0] got,
                             input logic [24:0] want);
    if (got !== want)
      report_mismatch($sformatf("result %0d %s: got %0d, expected %0d",
                                results_checked, name, got, want));
  endtask

  always @(posedge clk) begin
    result_t want;
    if (rst) begin
      order_vk        = 1'b0;
      issue_cap       = ISSUE_CAP_DEFAULT;
      clear_scan();
      span_reports_due.delete();
      fail_count      = 0;
      bytes_taken     = 0;
      results_checked = 0;
    end else begin
      // a byte taken on this edge still sees the old register values
      if (text.valid && text.ready) begin
        bytes_taken++;
        scan_text_byte(text.text_byte, text.block_end);
      end
      if (cfg.valid && cfg.ready) begin
        case (cfg.reg_index)
          CFG_COLUMN_ORDER:    order_vk  = cfg.data[0];
          CFG_MAX_ISSUE_COUNT: issue_cap = cfg.data;
          default: ;
        endcase
      end
      if (result.valid && result.ready) begin
        if (span_reports_due.size() == 0) begin
          report_mismatch($sformatf("unexpected result: kind %0d line %0d",
                                    result.result_kind, result.line_number));
        end else begin
          want = span_reports_due.pop_front();
          check_field("result_kind",  result.result_kind,  want.result_kind);
          check_field("line_number",  result.line_number,  want.line_number);
          check_field("key_offset",   result.key_offset,   want.key_offset);
          check_field("key_length",   result.key_length,   want.key_length);
          check_field("value_offset", result.value_offset, want.value_offset);
          check_field("value_length", result.value_length, want.value_length);
          check_field("block_ok",     result.block_ok,     want.block_ok);
          check_field("last_result",  result.last_result,  want.last_result);
        end
        results_checked++;
      end
    end
    pending = span_reports_due.size();
  end

endmodule

[test/tb_top.sv]
// Top of the line splitter testbench: clock, reset, byte and register stimulus,
// result-side backpressure and the verdict. Depends on tcls_pkg, the channel
// interfaces, two_column_text_line_splitter and tcls_span_monitor.
`timescale 1ns / 1ps

module tb_top;
  import tcls_pkg::*;

  localparam int RANDOM_BYTES = 480;   // stop point for the random part
  localparam int QUIET_TAIL   = 360;   // past this many bytes nobody idles
  localparam int DRAIN_PAUSE  = 8;     // covers the hold on a block end
  localparam int QUIET_LIMIT  = 2000;  // cycles with no request moving at all

  logic clk = 1'b0;
  logic rst;

  always #2 clk = ~clk;

  tcls_text_if   text_ch ();
  tcls_cfg_if    cfg_ch ();
  tcls_result_if res_ch ();

  two_column_text_line_splitter dut (
    .clk    (clk),
    .rst    (rst),
    .text   (text_ch),
    .cfg    (cfg_ch),
    .result (res_ch)
  );

  int fail_count;
  int pending;
  int bytes_taken;
  int results_checked;

  tcls_span_monitor span_mon (
    .clk             (clk),
    .rst             (rst),
    .text            (text_ch),
    .cfg             (cfg_ch),
    .result          (res_ch),
    .fail_count      (fail_count),
    .pending         (pending),
    .bytes_taken     (bytes_taken),
    .results_checked (results_checked)
  );

  // Handshake flags, sampled at the rising edge and read by the drivers at the
  // falling edge, so no driver ever races the block's own update.
  logic text_taken;
  logic cfg_taken;
  int   quiet_cycles;

  always @(posedge clk) begin
    text_taken <= text_ch.valid && text_ch.ready;
    cfg_taken  <= cfg_ch.valid && cfg_ch.ready;
  end

  // Watchdog: any request moving on any channel restarts the count.
  always @(posedge clk) begin
    if (rst || (text_ch.valid && text_ch.ready) || (cfg_ch.valid && cfg_ch.ready) ||
        (res_ch.valid && res_ch.ready)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles == QUIET_LIMIT) begin
        $display("timeout: no request moved for %0d cycles", QUIET_LIMIT);
        $display("two_column_text_line_splitter verification failed");
        $finish;
      end
    end
  end

  // Idle rates in percent per cycle; zero gives a stretch with no gaps.
  int send_gap_pct;
  int recv_gap_pct;

  // Result side: ready drops in bursts of random length.
  initial begin
    int hold;
    hold = 0;
    res_ch.ready <= 1'b0;
    @(negedge clk);
    forever begin
      if (hold > 0) begin
        hold--;
        res_ch.ready <= 1'b0;
      end else if (recv_gap_pct > 0 && $urandom_range(1, 100) <= recv_gap_pct) begin
        hold = $urandom_range(1, 19) - 1;
        res_ch.ready <= 1'b0;
      end else begin
        res_ch.ready <= 1'b1;
      end
      @(negedge clk);
    end
  end

  logic [7:0] blk[$];   // bytes of the block being built
  int         bytes_sent;
  int         blocks_sent;
  int         reg_writes;

  // Offer one byte request and return at the falling edge after it is taken.
  // Valid is left high; the next call either replaces the byte in the same
  // step or drops valid for a gap, so no stale byte is ever taken twice.
  task automatic push_byte(input logic [7:0] b, input logic fin);
    int gap;
    gap = 0;
    if (send_gap_pct > 0 && $urandom_range(1, 100) <= send_gap_pct)
      gap = $urandom_range(1, 19);
    if (gap > 0) begin
      text_ch.valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    text_ch.valid     <= 1'b1;
    text_ch.text_byte <= b;
    text_ch.block_end <= fin;
    @(negedge clk);
    while (!text_taken) @(negedge clk);
    bytes_sent++;
  endtask

  task automatic send_block();
    for (int i = 0; i < blk.size(); i++) push_byte(blk[i], i == blk.size() - 1);
    blocks_sent++;
  endtask

  // Stop offering bytes, let every expected result drain, then wait out the
  // block's own hold so a register write finds it idle.
  task automatic settle();
    text_ch.valid <= 1'b0;
    while (pending != 0) @(negedge clk);
    repeat (DRAIN_PAUSE) @(negedge clk);
  endtask

  task automatic write_reg(input cfg_index_t idx, input logic [15:0] value);
    cfg_ch.valid     <= 1'b1;
    cfg_ch.reg_index <= idx;
    cfg_ch.data      <= value;
    @(negedge clk);
    while (!cfg_taken) @(negedge clk);
    reg_writes++;
  endtask

  // Upper data bits of the order register are junk; only bit 0 counts.
  task automatic set_registers(input logic order, input logic [15:0] cap);
    logic [15:0] order_word;
    order_word = 16'($urandom_range(0, 65535));
    order_word[0] = order;
    write_reg(CFG_COLUMN_ORDER, order_word);
    write_reg(CFG_MAX_ISSUE_COUNT, cap);
    cfg_ch.valid <= 1'b0;
  endtask

  task automatic add_text(input string s);
    for (int i = 0; i < s.len(); i++) blk.push_back(s[i]);
  endtask

  task automatic add_blanks();
    repeat ($urandom_range(1, 3)) blk.push_back($urandom_range(0, 1) ? CH_SP : CH_TAB);
  endtask

  // Token bytes: mostly printable, some high bytes, now and then an inner NUL
  // that rejects the whole block.
  function automatic logic [7:0] token_char();
    int roll;
    roll = $urandom_range(0, 199);
    if (roll == 0) return CH_NUL;
    if (roll < 14) return 8'($urandom_range(8'h80, 8'hFF));
    return 8'($urandom_range(8'h21, 8'h7E));
  endfunction

  task automatic add_token();
    int len;
    len = ($urandom_range(0, 3) == 0) ? 1 : $urandom_range(2, 6);
    repeat (len) blk.push_back(token_char());
  endtask

  initial begin
    int          n_rec;
    int          sel;
    int          phase;
    int          phase_blocks;
    logic [15:0] cap;

    rst               <= 1'b1;
    text_ch.valid     <= 1'b0;
    text_ch.text_byte <= 8'h00;
    text_ch.block_end <= 1'b0;
    cfg_ch.valid      <= 1'b0;
    cfg_ch.reg_index  <= CFG_COLUMN_ORDER;
    cfg_ch.data       <= 16'h0000;
    send_gap_pct      = 0;
    recv_gap_pct      = 0;
    bytes_sent        = 0;
    blocks_sent       = 0;
    reg_writes        = 0;
    repeat (5) @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // Directed, key then value: entry whose one-byte value is followed by a
    // blank, a comment line, a lone token ended by CR LF, then a record with a
    // high byte and an inner NUL that the block end closes as an entry.
    set_registers(1'b0, ISSUE_CAP_DEFAULT);
    blk.delete();
    add_text("k v ");
    blk.push_back(CH_LF);
    add_text("#c");
    blk.push_back(CH_LF);
    blk.push_back(CH_TAB);
    add_text("q");
    blk.push_back(CH_CR);
    blk.push_back(CH_LF);
    blk.push_back(8'hFF);
    blk.push_back(CH_NUL);
    add_text(" zz");
    send_block();
    settle();

    // Directed, value then key: last token is the key, a lone token cut off by
    // the block end, a trailing NUL that must be dropped, and an empty block
    // made only of that trailing NUL.
    set_registers(1'b1, ISSUE_CAP_DEFAULT);
    blk.delete();
    add_text("a b k");
    blk.push_back(CH_LF);
    add_text("c");
    blk.push_back(CH_NUL);
    send_block();
    blk.delete();
    blk.push_back(CH_NUL);
    send_block();

    // Random blocks, mostly well-formed records with random content plus some
    // noise. Registers change every two blocks; the issue cap walks through
    // zero, its maximum, one, two and random values while the order toggles.
    phase        = 0;
    phase_blocks = 0;
    while (bytes_sent < RANDOM_BYTES) begin
      if (phase_blocks == 0) begin
        settle();
        case (phase % 5)
          0:       cap = 16'd0;
          1:       cap = 16'hFFFF;
          2:       cap = 16'd1;
          3:       cap = 16'd2;
          default: cap = 16'($urandom_range(3, 300));
        endcase
        set_registers(phase[0], cap);
      end

      if (bytes_sent >= QUIET_TAIL) begin
        send_gap_pct = 0;
        recv_gap_pct = 0;
      end else begin
        send_gap_pct = ($urandom_range(0, 2) == 0) ? 0 : 10;
        recv_gap_pct = ($urandom_range(0, 2) == 0) ? 0 : 12;
      end

      blk.delete();
      n_rec = $urandom_range(1, 5);
      for (int r = 0; r < n_rec; r++) begin
        if ($urandom_range(0, 3) == 0) add_blanks();
        sel = $urandom_range(0, 99);
        if (sel < 8) begin
          blk.push_back(CH_HASH);
          add_token();
        end else if (sel < 18) begin
          // only one column
          add_token();
          if ($urandom_range(0, 1) == 1) add_blanks();
        end else if (sel < 24) begin
          repeat ($urandom_range(1, 8)) blk.push_back(8'($urandom_range(0, 255)));
        end else if (sel < 28) begin
          add_blanks();
        end else begin
          // two or more tokens, sometimes with trailing blanks
          add_token();
          repeat ($urandom_range(1, 3)) begin
            add_blanks();
            add_token();
          end
          if ($urandom_range(0, 2) == 0) add_blanks();
        end
        if (r < n_rec - 1 || $urandom_range(0, 1) == 1) begin
          case ($urandom_range(0, 3))
            0: blk.push_back(CH_CR);
            1: begin
              blk.push_back(CH_CR);
              blk.push_back(CH_LF);
            end
            default: blk.push_back(CH_LF);
          endcase
        end
      end
      if ($urandom_range(0, 4) == 0) blk.push_back(CH_NUL);
      send_block();

      phase_blocks++;
      if (phase_blocks == 2) begin
        phase_blocks = 0;
        phase++;
      end
    end
    settle();

    $display("Covered %0d text bytes in %0d blocks, %0d register writes, both column orders",
             bytes_taken, blocks_sent, reg_writes);
    $display("Checked %0d results, issue caps from zero to full scale", results_checked);
    if (fail_count == 0 && pending == 0) begin
      $display("two_column_text_line_splitter verification clean");
    end else begin
      $display("two_column_text_line_splitter verification failed");
    end
    $finish;
  end

endmodule
